// ===== rtl/lmts_pkg.sv =====
package lmts_pkg;

  localparam int BYTE_W = 8;
  localparam int KEY_W  = 64;
  localparam int LEN_W  = 4;
  localparam int SLOT_W = 4;
  localparam int KEY_BYTES = KEY_W / BYTE_W;
  localparam int SLOT_LIMIT = 1 << SLOT_W;

  // operation codes
  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // utf-8 continuation byte test
  localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

  // best match so far, passed down the cell row (len zero = none)
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [SLOT_W-1:0] slot;
  } cand_t;

  // key load broadcast to the cells
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  bytes;
    logic [LEN_W-1:0]  len;
  } ld_t;

endpackage

// ===== rtl/lmts_in_if.sv =====
interface lmts_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 operation;
  logic [lmts_pkg::BYTE_W-1:0]          data_byte;
  logic                                 end_of_string;
  logic [lmts_pkg::SLOT_W-1:0]          key_slot;
  logic [lmts_pkg::KEY_W-1:0]           key_bytes;
  logic [lmts_pkg::LEN_W-1:0]           key_length;

  modport source (output valid, operation, data_byte, end_of_string, key_slot,
                  key_bytes, key_length, input ready);
  modport sink (input valid, operation, data_byte, end_of_string, key_slot,
                key_bytes, key_length, output ready);
endinterface

// ===== rtl/lmts_out_if.sv =====
interface lmts_out_if;
  logic                        valid;
  logic                        ready;
  logic                        is_replacement;
  logic [lmts_pkg::BYTE_W-1:0] literal_byte;
  logic [lmts_pkg::SLOT_W-1:0] key_index;
  logic                        last;

  modport source (output valid, is_replacement, literal_byte, key_index, last,
                  input ready);
  modport sink (input valid, is_replacement, literal_byte, key_index, last,
                output ready);
endinterface

// ===== rtl/longest_match_text_substituter_unit.sv =====
// Longest-match key substitution over a text byte stream. Keys are loaded one
// request at a time (operation = load). A text request that only fills the
// lookahead window leaves the unit idle; when the window is full or
// end_of_string is set, the unit makes decisions at the window head: the best
// candidate ripples down the row of NUM_KEYS key cells, one cell per cycle,
// then the result is handed to the output register once that register is free
// or being read. An end_of_string request drains the window with up to
// MAX_KEY_LEN such decisions and marks the final result with last. The input is
// taken again as soon as the decisions of a request are done, while the last
// result may still wait in the output register.
module longest_match_text_substituter_unit #(
  parameter int NUM_KEYS    = 16,
  parameter int MAX_KEY_LEN = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  lmts_in_if.sink    in_ch,
  lmts_out_if.source out_ch
);

  localparam int CNT_W = $clog2(NUM_KEYS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_KEYS - 1);
  localparam logic [lmts_pkg::LEN_W-1:0] MAX_LEN = lmts_pkg::LEN_W'(MAX_KEY_LEN);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic [lmts_pkg::LEN_W-1:0]      fill_r, fill_nxt;
  logic [lmts_pkg::BYTE_W-1:0]     win_r [MAX_KEY_LEN];
  logic [lmts_pkg::BYTE_W-1:0]     win_nxt [MAX_KEY_LEN];
  logic                            eos_r, eos_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_rep_r, out_rep_nxt;
  logic [lmts_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic [lmts_pkg::SLOT_W-1:0]     out_idx_r, out_idx_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            in_acc;
  logic                            emit_go;
  logic                            head_cont;
  logic [lmts_pkg::LEN_W-1:0]      best_len;
  logic [lmts_pkg::LEN_W-1:0]      drop;
  logic [lmts_pkg::LEN_W-1:0]      fill_left;
  logic [lmts_pkg::KEY_W-1:0]      win_flat;
  lmts_pkg::ld_t                   ld;
  lmts_pkg::cand_t                 chain [NUM_KEYS+1];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // window flattened for the cells, unused bytes zero
  always_comb begin
    win_flat = '0;
    for (int k = 0; k < MAX_KEY_LEN; k++) begin
      win_flat[k*lmts_pkg::BYTE_W +: lmts_pkg::BYTE_W] = win_r[k];
    end
  end

  // key load broadcast
  always_comb begin
    ld.en    = in_acc && (in_ch.operation == lmts_pkg::OP_LOAD);
    ld.slot  = in_ch.key_slot;
    ld.bytes = in_ch.key_bytes;
    ld.len   = in_ch.key_length;
  end

  // row of key cells
  assign chain[0] = '0;
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
    lmts_cell #(.IDX(i), .MAX_KEY_LEN(MAX_KEY_LEN)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ld     (ld),
      .win    (win_flat),
      .fill   (fill_r),
      .cand_i (chain[i]),
      .cand_o (chain[i+1])
    );
  end

  // decision at the window head
  assign head_cont = ((win_r[0] & lmts_pkg::CONT_MASK) == lmts_pkg::CONT_TAG);
  assign best_len  = head_cont ? '0 : chain[NUM_KEYS].len;
  assign drop      = (best_len != '0) ? best_len : lmts_pkg::LEN_W'(1);
  assign fill_left = fill_r - drop;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // sequencer, window and output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    win_nxt       = win_r;
    eos_nxt       = eos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rep_nxt   = out_rep_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_ch.operation == lmts_pkg::OP_TEXT)) begin
          eos_nxt = in_ch.end_of_string;
          if (fill_r < MAX_LEN) begin
            for (int k = 0; k < MAX_KEY_LEN; k++) begin
              if (fill_r == lmts_pkg::LEN_W'(k)) win_nxt[k] = in_ch.data_byte;
            end
            fill_nxt = fill_r + lmts_pkg::LEN_W'(1);
          end
          if ((fill_nxt >= MAX_LEN) || in_ch.end_of_string) begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_rep_nxt   = (best_len != '0);
          out_byte_nxt  = (best_len != '0) ? '0 : win_r[0];
          out_idx_nxt   = (best_len != '0) ? chain[NUM_KEYS].slot : '0;
          out_last_nxt  = eos_r && (fill_left == '0);
          for (int k = 0; k < MAX_KEY_LEN; k++) begin
            win_nxt[k] = '0;
            for (int m = 1; m <= MAX_KEY_LEN; m++) begin
              if ((drop == lmts_pkg::LEN_W'(m)) && (k + m < MAX_KEY_LEN)) begin
                win_nxt[k] = win_r[(k + m) % MAX_KEY_LEN];
              end
            end
          end
          fill_nxt = fill_left;
          cnt_nxt  = '0;
          if ((fill_left != '0) && ((fill_left >= MAX_LEN) || eos_r)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      eos_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_KEY_LEN; k++) win_r[k] <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      eos_r       <= eos_nxt;
      out_valid_r <= out_valid_nxt;
      win_r       <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rep_r  <= out_rep_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.is_replacement = out_rep_r;
  assign out_ch.literal_byte   = out_byte_r;
  assign out_ch.key_index      = out_idx_r;
  assign out_ch.last           = out_last_r;

  // window never over full, and never full while waiting for text
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= MAX_LEN) else $error("window fill out of range");

  a_idle_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fill_r < MAX_LEN)) else $error("idle with full window");

  // a result marked last leaves the window empty
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go && eos_r && (fill_left == '0) |=> (fill_r == '0) && (state_r == S_IDLE))
    else $error("window not drained after last result");

endmodule

// ===== rtl/lmts_cell.sv =====
module lmts_cell #(
  parameter int IDX         = 0,
  parameter int MAX_KEY_LEN = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lmts_pkg::ld_t               ld,
  input  logic [lmts_pkg::KEY_W-1:0]  win,
  input  logic [lmts_pkg::LEN_W-1:0]  fill,
  input  lmts_pkg::cand_t             cand_i,
  output lmts_pkg::cand_t             cand_o
);

  localparam logic [lmts_pkg::LEN_W-1:0] MAX_LEN = lmts_pkg::LEN_W'(MAX_KEY_LEN);
  localparam bit LOADABLE = (IDX < lmts_pkg::SLOT_LIMIT);
  localparam logic [lmts_pkg::SLOT_W-1:0] MY_SLOT = lmts_pkg::SLOT_W'(IDX);

  logic [lmts_pkg::KEY_W-1:0] key_r;
  logic [lmts_pkg::LEN_W-1:0] klen_r;
  lmts_pkg::cand_t            cand_r;
  lmts_pkg::cand_t            cand_nxt;
  logic                       we;
  logic                       hit;
  logic [lmts_pkg::KEY_BYTES-1:0] eq;

  assign we = ld.en && LOADABLE && (ld.slot == MY_SLOT);

  // key storage, length saturates at the window depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= '0;
    end else if (we) begin
      klen_r <= (ld.len > MAX_LEN) ? MAX_LEN : ld.len;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_r <= ld.bytes;
    end
  end

  // per-byte compare against the window head
  always_comb begin
    for (int j = 0; j < lmts_pkg::KEY_BYTES; j++) begin
      eq[j] = (key_r[j*lmts_pkg::BYTE_W +: lmts_pkg::BYTE_W] ==
               win[j*lmts_pkg::BYTE_W +: lmts_pkg::BYTE_W]) ||
              (lmts_pkg::LEN_W'(j) >= klen_r);
    end
  end

  assign hit = (klen_r != '0) && (klen_r <= fill) && (&eq);

  // take over only on a strictly longer key, so lower slots win ties
  always_comb begin
    cand_nxt = cand_i;
    if (hit && (klen_r > cand_i.len)) begin
      cand_nxt.len  = klen_r;
      cand_nxt.slot = MY_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else begin
      cand_r <= cand_nxt;
    end
  end

  assign cand_o = cand_r;

endmodule

// ===== dv/tb_lmts_channels.sv =====
`timescale 1ns / 100ps
package tb_lmts_types;

  // one text or load request as queued for the driver
  typedef struct packed {
    logic                        operation;
    logic [lmts_pkg::BYTE_W-1:0] data_byte;
    logic                        end_of_string;
    logic [lmts_pkg::SLOT_W-1:0] key_slot;
    logic [lmts_pkg::KEY_W-1:0]  key_bytes;
    logic [lmts_pkg::LEN_W-1:0]  key_length;
  } text_req_t;

  // one substitution token
  typedef struct packed {
    logic                        is_replacement;
    logic [lmts_pkg::BYTE_W-1:0] literal_byte;
    logic [lmts_pkg::SLOT_W-1:0] key_index;
    logic                        last;
  } token_t;
endpackage

// ===== dv/tb_longest_match_text_substituter_unit.sv =====
`timescale 1ns / 100ps
module tb_longest_match_text_substituter_unit;

  localparam int NKEYS = 16;
  localparam int MAXLEN = 8;

  logic clk;
  logic rst_n;

  lmts_in_if  in_ch ();
  lmts_out_if out_ch ();

  longest_match_text_substituter_unit #(
    .NUM_KEYS(NKEYS),
    .MAX_KEY_LEN(MAXLEN)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // predictor state
  logic [lmts_pkg::KEY_W-1:0] key_tab[NKEYS];
  int unsigned      key_len_tab[NKEYS];
  logic [7:0]       window[MAXLEN];
  int unsigned      window_fill;

  tb_lmts_types::text_req_t pending_reqs[$];
  tb_lmts_types::token_t    expected_tokens[$];

  int  mismatches;
  int  tokens_seen;
  int  replacements_seen;
  int  requests_sent;
  bit  idle_enable;
  bit  hold_sender;
  bit  hold_out;
  int  send_gap;
  int  recv_gap;

  // small alphabet so keys match often
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 8'h61 + 8'($urandom_range(0, 3));
    if (r == 7) return 8'h80 | 8'($urandom_range(0, 63));
    return 8'($urandom);
  endfunction

  // longest key match at window head
  function automatic int unsigned longest_key(output int unsigned slot);
    int unsigned best;
    bit ok;
    best = 0;
    slot = 0;
    for (int s = 0; s < NKEYS; s++) begin
      if (key_len_tab[s] == 0 || key_len_tab[s] > window_fill || key_len_tab[s] <= best)
        continue;
      ok = 1;
      for (int j = 0; j < key_len_tab[s]; j++)
        if (key_tab[s][8*j +: 8] != window[j]) ok = 0;
      if (ok) begin
        best = key_len_tab[s];
        slot = s;
      end
    end
    return best;
  endfunction

  // apply one accepted request to the predictor
  task automatic predict_substitution(input tb_lmts_types::text_req_t rq);
    int unsigned slot, len, n, cnt;
    tb_lmts_types::token_t t;
    n = 0;
    if (rq.operation == lmts_pkg::OP_LOAD) begin
      len = rq.key_length > MAXLEN ? MAXLEN : rq.key_length;
      key_tab[rq.key_slot] = rq.key_bytes;
      key_len_tab[rq.key_slot] = len;
      return;
    end
    if (window_fill < MAXLEN) begin
      window[window_fill] = rq.data_byte;
      window_fill++;
    end
    while (window_fill > 0 && (window_fill >= MAXLEN || rq.end_of_string)) begin
      len = 0;
      slot = 0;
      if ((window[0] & lmts_pkg::CONT_MASK) != lmts_pkg::CONT_TAG) len = longest_key(slot);
      t = '0;
      if (len > 0) begin
        t.is_replacement = 1;
        t.key_index = slot[3:0];
        cnt = len;
      end else begin
        t.literal_byte = window[0];
        cnt = 1;
      end
      for (int i = 0; i < MAXLEN; i++)
        window[i] = (i + cnt < window_fill) ? window[i + cnt] : 8'h00;
      window_fill -= cnt;
      expected_tokens.push_back(t);
      n++;
    end
    if (rq.end_of_string && n > 0)
      expected_tokens[expected_tokens.size() - 1].last = 1;
  endtask

  function automatic tb_lmts_types::text_req_t load_req(int slot, logic [63:0] kb, int len);
    tb_lmts_types::text_req_t r;
    r = '0;
    r.operation = lmts_pkg::OP_LOAD;
    r.key_slot = slot[3:0];
    r.key_bytes = kb;
    r.key_length = len[3:0];
    return r;
  endfunction

  function automatic tb_lmts_types::text_req_t char_req(logic [7:0] b, bit eos);
    tb_lmts_types::text_req_t r;
    r = '0;
    r.operation = lmts_pkg::OP_TEXT;
    r.data_byte = b;
    r.end_of_string = eos;
    r.key_bytes = {$urandom, $urandom};
    r.key_slot = 4'($urandom);
    r.key_length = 4'($urandom);
    return r;
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // driver, the head of the queue is the request on the bus
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      send_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_substitution(pending_reqs.pop_front());
        requests_sent <= requests_sent + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          in_ch.valid <= 0;
          send_gap <= send_gap - 1;
        end else if (hold_sender || pending_reqs.size() == 0) begin
          in_ch.valid <= 0;
        end else begin
          {in_ch.operation, in_ch.data_byte, in_ch.end_of_string, in_ch.key_slot,
           in_ch.key_bytes, in_ch.key_length} <= pending_reqs[0];
          in_ch.valid <= 1;
          if (idle_enable && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(1, 15);
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    tb_lmts_types::token_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 0;
      recv_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.is_replacement, out_ch.literal_byte, out_ch.key_index, out_ch.last};
        tokens_seen++;
        if (got.is_replacement) replacements_seen++;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected token %p", got);
        end else begin
          want = expected_tokens.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) $display("token mismatch: expected %p actual %p", want, got);
          end
        end
      end
      if (hold_out) begin
        out_ch.ready <= 0;
      end else if (recv_gap > 0) begin
        out_ch.ready <= 0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ch.ready <= 1;
        if (idle_enable && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 15);
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  // random well-formed text: strings of mixed bytes, keys reloaded now and then
  task automatic queue_random_text(int count);
    int len;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        len = $urandom_range(0, 15);
        pending_reqs.push_back(load_req($urandom_range(0, 15),
          {8'h61 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3)),
           8'h61 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3)),
           8'h61 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3)),
           8'h61 + 8'($urandom_range(0, 3)), 8'h61 + 8'($urandom_range(0, 3))},
          $urandom_range(0, 3) == 0 ? len : $urandom_range(1, 3)));
      end else begin
        pending_reqs.push_back(char_req(pick_byte(), $urandom_range(0, 11) == 0));
      end
    end
    pending_reqs.push_back(char_req(pick_byte(), 1));
  endtask

  initial begin
    mismatches = 0;
    tokens_seen = 0;
    replacements_seen = 0;
    requests_sent = 0;
    idle_enable = 1;
    hold_sender = 0;
    hold_out = 0;
    window_fill = 0;
    foreach (key_tab[i]) begin
      key_tab[i] = '0;
      key_len_tab[i] = 0;
    end
    foreach (window[i]) window[i] = 0;
    in_ch.valid = 0;
    in_ch.operation = lmts_pkg::OP_TEXT;
    in_ch.data_byte = 0;
    in_ch.end_of_string = 0;
    in_ch.key_slot = 0;
    in_ch.key_bytes = 0;
    in_ch.key_length = 0;
    out_ch.ready = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // directed: text before any key, continuation head, key table edges
    pending_reqs.push_back(char_req(8'h00, 0));
    pending_reqs.push_back(char_req(8'hFF, 0));
    pending_reqs.push_back(char_req(8'h80, 1));
    pending_reqs.push_back(load_req(0, 64'h0000_0000_0000_6261, 2));       // "ab"
    pending_reqs.push_back(load_req(1, 64'h0000_0000_0063_6261, 3));       // "abc"
    pending_reqs.push_back(load_req(2, 64'hFFFF_FFFF_FFFF_6261, 2));       // dup of slot 0
    pending_reqs.push_back(load_req(15, 64'h6161_6161_6161_6161, 15));     // saturates to 8
    pending_reqs.push_back(load_req(3, 64'h0000_0000_0000_0080, 1));       // continuation key
    pending_reqs.push_back(load_req(4, 64'hFFFF_FFFF_FFFF_FFFF, 0));       // empty
    pending_reqs.push_back(load_req(5, 64'h0000_0000_0000_0061, 1));       // "a"
    for (int i = 0; i < 9; i++) pending_reqs.push_back(char_req(8'h61, 0));
    pending_reqs.push_back(char_req(8'h80, 0));
    pending_reqs.push_back(char_req(8'h61, 0));
    pending_reqs.push_back(char_req(8'h62, 0));
    pending_reqs.push_back(char_req(8'h63, 1));
    pending_reqs.push_back(char_req(8'h62, 1));
    wait_drained();

    // sender held while requests are queued, then receiver holds off while input fills
    hold_sender <= 1;
    @(posedge clk);
    queue_random_text(30);
    repeat (20) @(posedge clk);
    fork
      begin
        hold_out <= 1;
        repeat (400) @(posedge clk);
        hold_out <= 0;
      end
    join_none
    hold_sender <= 0;
    wait_drained();

    queue_random_text(140);
    wait_drained();

    // last stretch with no idling at all
    idle_enable <= 0;
    queue_random_text(40);
    wait_drained();
    repeat (60) @(posedge clk);

    $display("requests %0d, tokens %0d (replacements %0d) across loads, flushes and stalls",
             requests_sent, tokens_seen, replacements_seen);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatches %0d, leftover %0d", mismatches, expected_tokens.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
